// File: hdl/euler_to_quaternion_top_defines.svh
// Assertion macros shared by the euler_to_quaternion RTL.
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define E2Q_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define E2Q_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/e2q_pkg.sv
// Types, constants and the arctangent table of the Euler to quaternion converter.
package e2q_pkg;

  localparam int ANG_W  = 16;  // Q3.13 input angle
  localparam int HALF_W = 17;  // half angle after yaw reference subtract
  localparam int WRAP_W = 18;  // half angle during wrap and fold
  localparam int XW     = 34;  // CORDIC x and y, Q.30
  localparam int ZW     = 33;  // CORDIC residual angle, Q.30
  localparam int CW     = 18;  // sine and cosine, Q.16
  localparam int PW     = 51;  // triple products and sums, Q.48
  localparam int QW     = 16;  // quaternion parts, Q1.14

  localparam int PI_Q14      = 51472;
  localparam int TWO_PI_Q14  = 102944;
  localparam int HALF_PI_Q14 = 25736;

  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
  localparam logic signed [ZW-1:0] ZMAX_Q30 = ZW'(1686634496);  // half pi in Q.30
  localparam logic signed [XW-1:0] RND_Q30  = XW'(8192);
  localparam logic signed [XW-1:0] CLIP_Q16 = XW'(65536);
  localparam logic signed [PW-1:0] RND_Q48  = PW'(64'sd8589934592);
  localparam logic signed [PW-1:0] CLIP_Q14 = PW'(16384);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;  // cosine must be negated
  } lane_t;

  // atan(2^-idx) in Q.30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = ZW'(843314856);
      1:       a = ZW'(497837829);
      2:       a = ZW'(263043836);
      3:       a = ZW'(133525158);
      4:       a = ZW'(67021686);
      5:       a = ZW'(33543515);
      6:       a = ZW'(16775850);
      7:       a = ZW'(8388437);
      8:       a = ZW'(4194282);
      9:       a = ZW'(2097149);
      10:      a = ZW'(1048575);
      11:      a = ZW'(524287);
      12:      a = ZW'(262143);
      13:      a = ZW'(131071);
      14:      a = ZW'(65535);
      15:      a = ZW'(32767);
      16:      a = ZW'(16383);
      17:      a = ZW'(8191);
      18:      a = ZW'(4095);
      19:      a = ZW'(2047);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/euler_to_quaternion_top.sv
// Euler angles (ZYX) to quaternion converter: a row of CORDIC cells between input and output cells.
//
// Input channel: roll_angle, pitch_angle, yaw_angle (signed Q3.13 radians) with in_valid and
// in_stall; a transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel: quat_w, quat_x, quat_y, quat_z (signed Q1.14) with out_valid and out_stall.
// cfg_wr_en with cfg_wr_data loads the yaw reference, subtracted from every yaw angle; write it
// only while no item is in flight.
// Cells from input transfer to out_valid: two input cells, one CORDIC cell per stage, five output
// cells (round, two multiply levels, sum, saturate). Throughput: one item per cycle while out_stall
// is low, since every cell then passes its data on each cycle.
// Each cell advances when it is empty or the cell after it advances, so bubbles are squeezed out
// and new items still enter while a result waits on out_stall; in_stall rises only when every
// cell holds an item and the output is stalled.
// Reset (rst, synchronous) clears all valid bits and sets the yaw reference to zero.
`include "euler_to_quaternion_top_defines.svh"

module euler_to_quaternion_top #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic signed [e2q_pkg::ANG_W-1:0] cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [e2q_pkg::ANG_W-1:0] roll_angle,
  input  logic signed [e2q_pkg::ANG_W-1:0] pitch_angle,
  input  logic signed [e2q_pkg::ANG_W-1:0] yaw_angle,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [e2q_pkg::QW-1:0]    quat_w,
  output logic signed [e2q_pkg::QW-1:0]    quat_x,
  output logic signed [e2q_pkg::QW-1:0]    quat_y,
  output logic signed [e2q_pkg::QW-1:0]    quat_z
);

  localparam int NSTG = CORDIC_STAGES + 7;

  logic [NSTG-1:0]                  v;
  logic [NSTG-1:0]                  en;
  logic signed [e2q_pkg::ANG_W-1:0] yaw_ref;
  e2q_pkg::lane_t                   lanes [CORDIC_STAGES+1][3];

  // a cell advances when empty or when its successor advances
  assign en[NSTG-1] = !v[NSTG-1] || !out_stall;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      yaw_ref <= '0;
    end else begin
      if (cfg_wr_en) begin
        yaw_ref <= cfg_wr_data;
      end
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  e2q_prep u_prep (
    .clk         (clk),
    .en          (en[1:0]),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .yaw_ref     (yaw_ref),
    .lane_out    (lanes[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    e2q_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .en       (en[2+i]),
      .lane_in  (lanes[i]),
      .lane_out (lanes[i+1])
    );
  end

  e2q_quat u_quat (
    .clk     (clk),
    .en      (en[NSTG-1 -: 5]),
    .lane_in (lanes[CORDIC_STAGES]),
    .quat_w  (quat_w),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z)
  );

  `E2Q_ASSERT(a_stall_full, clk, rst, in_stall, out_valid && out_stall, "stall with free cell")
  `E2Q_ASSERT_NEXT(a_drain, clk, rst, out_valid && !out_stall && !v[NSTG-2], !out_valid,
    "result repeated")
  `E2Q_ASSERT(a_fold_range, clk, rst, v[1],
    lanes[0][2].z <= e2q_pkg::ZMAX_Q30 && lanes[0][2].z >= -e2q_pkg::ZMAX_Q30,
    "folded yaw out of range")
  `E2Q_ASSERT(a_quat_sat, clk, rst, out_valid,
    quat_w <= 16'sd16384 && quat_w >= -16'sd16384, "quat_w beyond saturation")

endmodule

// File: hdl/e2q_prep.sv
// Input cells: yaw reference subtract, then wrap and fold of the three half angles.
module e2q_prep (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic signed [e2q_pkg::ANG_W-1:0]  roll_angle,
  input  logic signed [e2q_pkg::ANG_W-1:0]  pitch_angle,
  input  logic signed [e2q_pkg::ANG_W-1:0]  yaw_angle,
  input  logic signed [e2q_pkg::ANG_W-1:0]  yaw_ref,
  output e2q_pkg::lane_t                    lane_out [3]
);

  localparam logic signed [e2q_pkg::WRAP_W-1:0] PI_W      = e2q_pkg::WRAP_W'(e2q_pkg::PI_Q14);
  localparam logic signed [e2q_pkg::WRAP_W-1:0] TWO_PI_W  =
    e2q_pkg::WRAP_W'(e2q_pkg::TWO_PI_Q14);
  localparam logic signed [e2q_pkg::WRAP_W-1:0] HALF_PI_W =
    e2q_pkg::WRAP_W'(e2q_pkg::HALF_PI_Q14);

  logic signed [e2q_pkg::HALF_W-1:0] half [3];
  e2q_pkg::lane_t                    lane_next [3];

  // Wrap into [-pi, pi], fold into [-pi/2, pi/2], seed the CORDIC.
  function automatic e2q_pkg::lane_t fold(input logic signed [e2q_pkg::HALF_W-1:0] h);
    logic signed [e2q_pkg::WRAP_W-1:0] w;
    logic signed [e2q_pkg::ZW-1:0]     zt;
    e2q_pkg::lane_t                    l;
    w = e2q_pkg::WRAP_W'(h);
    if (w > PI_W) begin
      w = w - TWO_PI_W;
    end else if (w < -PI_W) begin
      w = w + TWO_PI_W;
    end
    l.neg = 1'b0;
    if (w > HALF_PI_W) begin
      w     = PI_W - w;
      l.neg = 1'b1;
    end else if (w < -HALF_PI_W) begin
      w     = -PI_W - w;
      l.neg = 1'b1;
    end
    zt  = e2q_pkg::ZW'(w);
    l.z = zt <<< 16;
    l.x = e2q_pkg::GAIN_Q30;
    l.y = '0;
    return l;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_next[i] = fold(half[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      half[0] <= e2q_pkg::HALF_W'(roll_angle);
      half[1] <= e2q_pkg::HALF_W'(pitch_angle);
      half[2] <= e2q_pkg::HALF_W'(yaw_angle) - e2q_pkg::HALF_W'(yaw_ref);
    end
    if (en[1]) begin
      lane_out <= lane_next;
    end
  end

endmodule

// File: hdl/e2q_cordic_cell.sv
// One rotation-mode CORDIC cell working on the roll, pitch and yaw lanes side by side.
module e2q_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           en,
  input  e2q_pkg::lane_t lane_in  [3],
  output e2q_pkg::lane_t lane_out [3]
);

  localparam logic signed [e2q_pkg::ZW-1:0] ATAN = e2q_pkg::atan_q30(STAGE);

  logic signed [e2q_pkg::XW-1:0] xs [3];
  logic signed [e2q_pkg::XW-1:0] ys [3];
  e2q_pkg::lane_t                lane_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xs[i] = $signed(lane_in[i].x) >>> STAGE;
      ys[i] = $signed(lane_in[i].y) >>> STAGE;
      lane_next[i].neg = lane_in[i].neg;
      // rotate toward zero residual angle
      if (!lane_in[i].z[e2q_pkg::ZW-1]) begin
        lane_next[i].x = lane_in[i].x - ys[i];
        lane_next[i].y = lane_in[i].y + xs[i];
        lane_next[i].z = lane_in[i].z - ATAN;
      end else begin
        lane_next[i].x = lane_in[i].x + ys[i];
        lane_next[i].y = lane_in[i].y - xs[i];
        lane_next[i].z = lane_in[i].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

// File: hdl/e2q_quat.sv
// Output cells: sine and cosine rounding, triple products, sums and Q1.14 saturation.
module e2q_quat (
  input  logic                             clk,
  input  logic [4:0]                       en,
  input  e2q_pkg::lane_t                   lane_in [3],
  output logic signed [e2q_pkg::QW-1:0]    quat_w,
  output logic signed [e2q_pkg::QW-1:0]    quat_x,
  output logic signed [e2q_pkg::QW-1:0]    quat_y,
  output logic signed [e2q_pkg::QW-1:0]    quat_z
);

  localparam int CW = e2q_pkg::CW;
  localparam int PW = e2q_pkg::PW;

  // cosine and sine per lane: 0 roll, 1 pitch, 2 yaw
  logic signed [CW-1:0]   cs_c [3];
  logic signed [CW-1:0]   cs_s [3];
  logic signed [CW-1:0]   c_next [3];
  logic signed [CW-1:0]   s_next [3];

  logic signed [2*CW-1:0] p_cc, p_ss, p_cs, p_sc;
  logic signed [CW-1:0]   cy1, sy1;

  logic signed [PW-1:0]   t_ccc, t_sss, t_scc, t_css, t_csc, t_scs, t_ccs, t_ssc;
  logic signed [PW-1:0]   sum_w, sum_x, sum_y, sum_z;

  function automatic logic signed [CW-1:0] to_q16(input logic signed [e2q_pkg::XW-1:0] v);
    logic signed [e2q_pkg::XW-1:0] t;
    t = (v + e2q_pkg::RND_Q30) >>> 14;
    if (t > e2q_pkg::CLIP_Q16) begin
      t = e2q_pkg::CLIP_Q16;
    end else if (t < -e2q_pkg::CLIP_Q16) begin
      t = -e2q_pkg::CLIP_Q16;
    end
    return t[CW-1:0];
  endfunction

  function automatic logic signed [e2q_pkg::QW-1:0] to_q14(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + e2q_pkg::RND_Q48) >>> 34;
    if (t > e2q_pkg::CLIP_Q14) begin
      t = e2q_pkg::CLIP_Q14;
    end else if (t < -e2q_pkg::CLIP_Q14) begin
      t = -e2q_pkg::CLIP_Q14;
    end
    return t[e2q_pkg::QW-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_next[i] = to_q16(lane_in[i].x);
      s_next[i] = to_q16(lane_in[i].y);
      if (lane_in[i].neg) begin
        c_next[i] = -c_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cs_c <= c_next;
      cs_s <= s_next;
    end
    if (en[1]) begin
      p_cc <= (2*CW)'(cs_c[0]) * (2*CW)'(cs_c[1]);
      p_ss <= (2*CW)'(cs_s[0]) * (2*CW)'(cs_s[1]);
      p_cs <= (2*CW)'(cs_c[0]) * (2*CW)'(cs_s[1]);
      p_sc <= (2*CW)'(cs_s[0]) * (2*CW)'(cs_c[1]);
      cy1  <= cs_c[2];
      sy1  <= cs_s[2];
    end
    if (en[2]) begin
      t_ccc <= PW'(p_cc) * PW'(cy1);
      t_sss <= PW'(p_ss) * PW'(sy1);
      t_scc <= PW'(p_sc) * PW'(cy1);
      t_css <= PW'(p_cs) * PW'(sy1);
      t_csc <= PW'(p_cs) * PW'(cy1);
      t_scs <= PW'(p_sc) * PW'(sy1);
      t_ccs <= PW'(p_cc) * PW'(sy1);
      t_ssc <= PW'(p_ss) * PW'(cy1);
    end
    if (en[3]) begin
      sum_w <= t_ccc + t_sss;
      sum_x <= t_scc - t_css;
      sum_y <= t_csc + t_scs;
      sum_z <= t_ccs - t_ssc;
    end
    if (en[4]) begin
      quat_w <= to_q14(sum_w);
      quat_x <= to_q14(sum_x);
      quat_y <= to_q14(sum_y);
      quat_z <= to_q14(sum_z);
    end
  end

endmodule
